// ===== hdl/crpi_pkg.sv =====
package crpi_pkg;

    localparam int TIME_BITS_DEF     = 48;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int POS_BITS          = 32;
    localparam int CHORD_BITS        = POS_BITS + 1;
    // tangent magnitude limit is 2^TAN_SHIFT lsb
    localparam int TAN_SHIFT         = 35;
    localparam int TAN_BITS          = TAN_SHIFT + 2;
    // scale (2 stages) + limit check + quotient bits + sign stage
    localparam int TAN_LAT           = TAN_SHIFT + 4;
    localparam int BLEND_LAT         = 8;

    typedef struct packed {
        logic signed [POS_BITS-1:0] p1;
        logic signed [POS_BITS-1:0] p2;
        logic signed [TAN_BITS-1:0] m1;
        logic signed [TAN_BITS-1:0] m2;
        logic                       degen;
        logic                       tclip;
    } side_t;

    typedef struct packed {
        logic signed [POS_BITS-1:0] p1;
        logic signed [POS_BITS-1:0] p2;
        logic                       degen;
    } knot_t;

endpackage

// ===== hdl/crpi_delay.sv =====
module crpi_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

// ===== hdl/crpi_frac_div.sv =====
module crpi_frac_div #(
    parameter int TIME_BITS     = crpi_pkg::TIME_BITS_DEF,
    parameter int FRACTION_BITS = crpi_pkg::FRACTION_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic [TIME_BITS-1:0]     num,
    input  logic [TIME_BITS-1:0]     den,
    input  logic                     lo,
    input  logic                     hi,
    output logic [FRACTION_BITS:0]   u
);

    localparam int TB = TIME_BITS;
    localparam int F  = FRACTION_BITS;
    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

    logic [TB-1:0] rem_reg [F];
    logic [TB-1:0] den_reg [F];
    logic [F-1:0]  q_reg   [F];
    logic          lo_reg  [F];
    logic          hi_reg  [F];
    logic [F:0]    u_reg;

    // one quotient bit per stage, restoring
    for (genvar i = 0; i < F; i++)
    begin : g_stage
        logic [TB-1:0] rem_in;
        logic [TB-1:0] den_in;
        logic [F-1:0]  q_in;
        logic          lo_in;
        logic          hi_in;
        logic [TB:0]   shl;
        logic [TB:0]   diff;
        logic          take;

        if (i == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign q_in   = '0;
            assign lo_in  = lo;
            assign hi_in  = hi;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[i-1];
            assign den_in = den_reg[i-1];
            assign q_in   = q_reg[i-1];
            assign lo_in  = lo_reg[i-1];
            assign hi_in  = hi_reg[i-1];
        end

        assign shl  = {rem_in, 1'b0};
        assign diff = shl - {1'b0, den_in};
        assign take = shl >= {1'b0, den_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= take ? diff[TB-1:0] : shl[TB-1:0];
                den_reg[i] <= den_in;
                q_reg[i]   <= {q_in[F-2:0], take};
                lo_reg[i]  <= lo_in;
                hi_reg[i]  <= hi_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (lo_reg[F-1])
            begin
                u_reg <= '0;
            end
            else if (hi_reg[F-1])
            begin
                u_reg <= ONE;
            end
            else
            begin
                u_reg <= {1'b0, q_reg[F-1]};
            end
        end
    end

    assign u = u_reg;

endmodule

// ===== hdl/crpi_tan_div.sv =====
module crpi_tan_div #(
    parameter int TIME_BITS = crpi_pkg::TIME_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic signed [crpi_pkg::CHORD_BITS-1:0] chord,
    input  logic [TIME_BITS-1:0]                  span,
    input  logic [TIME_BITS-1:0]                  den,
    output logic signed [crpi_pkg::TAN_BITS-1:0]  tan,
    output logic                                  clip
);

    localparam int TB = TIME_BITS;
    localparam int CW = crpi_pkg::CHORD_BITS;
    localparam int KS = crpi_pkg::TAN_SHIFT;
    localparam int NS = KS + 1;
    localparam int QW = KS + 1;
    localparam int TW = crpi_pkg::TAN_BITS;
    localparam int SL = (TB + 1) / 2;
    localparam int SH = TB - SL;
    localparam int PW = CW + TB;
    localparam int RW = TB + KS + 1;

    logic [CW-1:0]    mag;
    logic [CW+SL-1:0] pl_reg;
    logic [CW+SH-1:0] ph_reg;
    logic [TB-1:0]    den1_reg;
    logic             neg1_reg;
    logic [PW-1:0]    prod_reg;
    logic [TB-1:0]    den2_reg;
    logic             neg2_reg;

    logic [RW-1:0]    rem_reg  [NS];
    logic [TB-1:0]    den_reg  [NS];
    logic [QW-1:0]    q_reg    [NS];
    logic             neg_reg  [NS];
    logic             clip_reg [NS];

    logic signed [TW-1:0] tan_reg;
    logic                 clipo_reg;

    assign mag = chord[CW-1] ? CW'(-chord) : CW'(chord);

    // magnitude times span as two half products, then summed
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pl_reg   <= mag * span[SL-1:0];
            ph_reg   <= mag * span[TB-1:SL];
            den1_reg <= den;
            neg1_reg <= chord[CW-1];
            prod_reg <= PW'(pl_reg) + (PW'(ph_reg) << SL);
            den2_reg <= den1_reg;
            neg2_reg <= neg1_reg;
        end
    end

    // first stage is the limit check, then one quotient bit per stage
    for (genvar j = 0; j < NS; j++)
    begin : g_bit
        localparam int K = KS - j;
        logic [RW-1:0] rem_in;
        logic [TB-1:0] den_in;
        logic [QW-1:0] q_in;
        logic          neg_in;
        logic          clip_in;
        logic [RW-1:0] dsh;
        logic [RW-1:0] diff;
        logic          take;

        if (j == 0)
        begin : g_first
            assign rem_in  = RW'(prod_reg);
            assign den_in  = den2_reg;
            assign q_in    = '0;
            assign neg_in  = neg2_reg;
            assign clip_in = 1'b0;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[j-1];
            assign den_in  = den_reg[j-1];
            assign q_in    = q_reg[j-1];
            assign neg_in  = neg_reg[j-1];
            assign clip_in = clip_reg[j-1];
        end

        assign dsh  = RW'(den_in) << K;
        assign diff = rem_in - dsh;
        assign take = rem_in >= dsh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                // on clipping the remainder is dropped so no lower bit is set
                rem_reg[j]  <= take ? ((j == 0) ? '0 : diff) : rem_in;
                den_reg[j]  <= den_in;
                q_reg[j]    <= take ? (q_in | (QW'(1) << K)) : q_in;
                neg_reg[j]  <= neg_in;
                clip_reg[j] <= clip_in | ((j == 0) && take);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tan_reg   <= neg_reg[NS-1] ? -signed'(TW'(q_reg[NS-1]))
                                       : signed'(TW'(q_reg[NS-1]));
            clipo_reg <= clip_reg[NS-1];
        end
    end

    assign tan  = tan_reg;
    assign clip = clipo_reg;

endmodule

// ===== hdl/crpi_blend.sv =====
module crpi_blend #(
    parameter int FRACTION_BITS = crpi_pkg::FRACTION_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic [FRACTION_BITS:0]               u,
    input  crpi_pkg::side_t                      side,
    output logic signed [crpi_pkg::POS_BITS-1:0] pos,
    output logic                                 degen,
    output logic                                 sat
);

    localparam int F   = FRACTION_BITS;
    localparam int HW  = F + 4;
    localparam int AW  = HW + crpi_pkg::TAN_BITS + 2;
    localparam int RWD = AW - F;
    localparam int PB  = crpi_pkg::POS_BITS;

    localparam logic signed [HW-1:0] ONE_H = {{(HW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
    localparam logic signed [AW-1:0] HALF  = {{(AW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
    localparam logic signed [PB-1:0] PMAX  = {1'b0, {(PB-1){1'b1}}};
    localparam logic signed [PB-1:0] PMIN  = {1'b1, {(PB-1){1'b0}}};
    localparam logic signed [RWD-1:0] RMAX = RWD'(PMAX);
    localparam logic signed [RWD-1:0] RMIN = RWD'(PMIN);

    localparam int BL = crpi_pkg::BLEND_LAT;
    crpi_pkg::side_t side_reg [BL];

    logic [2*F+1:0]       uu_reg;
    logic [F:0]           u1_reg;
    logic [F:0]           u1b_reg;
    logic [F:0]           u2_reg;
    logic [F:0]           u2b_reg;
    logic [2*F+1:0]       u2u_reg;
    logic [F:0]           u3b_reg;
    logic [F:0]           u3_src;
    logic signed [HW-1:0] su, su2, su3;
    logic signed [HW-1:0] h00_reg, h10_reg, h01_reg, h11_reg;
    logic signed [AW-1:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic signed [AW-1:0] sa_reg, sb_reg, acc_reg;
    logic signed [RWD-1:0] r;
    logic signed [PB-1:0] pos_reg;
    logic                 degen_reg;
    logic                 sat_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side;
            for (int i = 1; i < BL; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign u3_src = u2u_reg[2*F:F];
    assign su     = signed'(HW'(u3b_reg));
    assign su2    = signed'(HW'(u2b_reg));
    assign su3    = signed'(HW'(u3_src));

    // basis powers, then hermite weights, products, adder tree, round
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            uu_reg  <= u * u;
            u1_reg  <= u;
            u1b_reg <= u1_reg;
            u2_reg  <= uu_reg[2*F:F];
            u2b_reg <= u2_reg;
            u2u_reg <= u2_reg * u1b_reg;
            u3b_reg <= u1b_reg;
            h00_reg <= (su3 <<< 1) - (su2 <<< 1) - su2 + ONE_H;
            h10_reg <= su3 - (su2 <<< 1) + su;
            h01_reg <= (su2 <<< 1) + su2 - (su3 <<< 1);
            h11_reg <= su3 - su2;
            pa_reg  <= AW'(h00_reg) * AW'(side_reg[3].p1);
            pb_reg  <= AW'(h10_reg) * AW'(side_reg[3].m1);
            pc_reg  <= AW'(h01_reg) * AW'(side_reg[3].p2);
            pd_reg  <= AW'(h11_reg) * AW'(side_reg[3].m2);
            sa_reg  <= pa_reg + pb_reg;
            sb_reg  <= pc_reg + pd_reg;
            acc_reg <= sa_reg + sb_reg + HALF;
        end
    end

    // u2 pipeline: u2b aligns with u2u, u3b carries u alongside
    assign r = acc_reg[AW-1:F];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (side_reg[6].degen)
            begin
                pos_reg   <= side_reg[6].p1;
                degen_reg <= 1'b1;
                sat_reg   <= 1'b0;
            end
            else if (r > RMAX)
            begin
                pos_reg   <= PMAX;
                degen_reg <= 1'b0;
                sat_reg   <= 1'b1;
            end
            else if (r < RMIN)
            begin
                pos_reg   <= PMIN;
                degen_reg <= 1'b0;
                sat_reg   <= 1'b1;
            end
            else
            begin
                pos_reg   <= r[PB-1:0];
                degen_reg <= 1'b0;
                sat_reg   <= side_reg[6].tclip;
            end
        end
    end

    assign pos   = pos_reg;
    assign degen = degen_reg;
    assign sat   = sat_reg;

endmodule

// ===== hdl/catmull_rom_position_interpolator.sv =====
// non-uniform catmull-rom position interpolator, one axis per word
// slave channel s_*: one query word (four knot times, query time, four
// knot positions); master channel m_*: one result word per query word
// results leave in the order the queries came in
// throughput: one word per cycle unless stalled; the two 36-step
// tangent dividers and the FRACTION_BITS-step fraction divider
// are fully pipelined, one quotient bit per stage, so every stage
// can hold a different word
// stall: the whole pipeline holds while m_tvalid is high and m_tready is
// low; s_tready drops in that cycle, nothing is lost or repeated
// reset: rst_n clears all valid bits, the pipeline comes up empty and
// s_tready is high; payload registers keep whatever they hold
// degenerate segment (end time not after start time) returns the start
// position with the degenerate flag and no saturation flag
module catmull_rom_position_interpolator #(
    parameter int TIME_BITS     = crpi_pkg::TIME_BITS_DEF,
    parameter int FRACTION_BITS = crpi_pkg::FRACTION_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // time_before, time_start, time_end, time_after, query_time,
    // pos_before, pos_start, pos_end, pos_after, zero fill to bytes
    input  logic [((5*TIME_BITS+4*crpi_pkg::POS_BITS+7)/8)*8-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // pos_out
    output logic [crpi_pkg::POS_BITS-1:0] m_tdata,
    // degenerate_segment, saturated
    output logic [1:0]           m_tuser
);

    localparam int TB  = TIME_BITS;
    localparam int F   = FRACTION_BITS;
    localparam int PB  = crpi_pkg::POS_BITS;
    localparam int CW  = crpi_pkg::CHORD_BITS;
    localparam int TW  = crpi_pkg::TAN_BITS;
    localparam int LT  = crpi_pkg::TAN_LAT;
    localparam int LF  = F + 1;
    localparam int LAT = 1 + LT + crpi_pkg::BLEND_LAT;
    localparam int KW  = $bits(crpi_pkg::knot_t);

    logic en;

    logic [TB-1:0] t0, t1, t2, t3, tq;
    logic signed [PB-1:0] p0, p1, p2, p3;

    // input stage registers
    logic [TB-1:0] dt_reg, num_reg, d1_reg, d2_reg;
    logic          lo_reg, hi_reg;
    logic signed [CW-1:0] c1_reg, c2_reg;
    crpi_pkg::knot_t knot_reg;

    logic [F:0]    u_raw, u_dly;
    logic signed [TW-1:0] m1, m2;
    logic          clip1, clip2;
    crpi_pkg::knot_t knot_dly;
    crpi_pkg::side_t side;

    logic signed [PB-1:0] pos;
    logic          degen, sat;

    logic [LAT-1:0] vld_reg, vld_next;

    // the whole pipeline advances unless a finished word is held
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    assign t0 = s_tdata[TB-1:0];
    assign t1 = s_tdata[2*TB-1:TB];
    assign t2 = s_tdata[3*TB-1:2*TB];
    assign t3 = s_tdata[4*TB-1:3*TB];
    assign tq = s_tdata[5*TB-1:4*TB];
    assign p0 = s_tdata[5*TB+PB-1:5*TB];
    assign p1 = s_tdata[5*TB+2*PB-1:5*TB+PB];
    assign p2 = s_tdata[5*TB+3*PB-1:5*TB+2*PB];
    assign p3 = s_tdata[5*TB+4*PB-1:5*TB+3*PB];

    // differences, clamps and segment tests
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dt_reg         <= t2 - t1;
            num_reg        <= tq - t1;
            lo_reg         <= tq <= t1;
            hi_reg         <= tq >= t2;
            d1_reg         <= (t2 > t0) ? (t2 - t0) : TB'(1);
            d2_reg         <= (t3 > t1) ? (t3 - t1) : TB'(1);
            c1_reg         <= CW'(p2) - CW'(p0);
            c2_reg         <= CW'(p3) - CW'(p1);
            knot_reg.p1    <= p1;
            knot_reg.p2    <= p2;
            knot_reg.degen <= t2 <= t1;
        end
    end

    crpi_frac_div #(
        .TIME_BITS     (TB),
        .FRACTION_BITS (F)
    ) u_frac (
        .clk (clk),
        .en  (en),
        .num (num_reg),
        .den (dt_reg),
        .lo  (lo_reg),
        .hi  (hi_reg),
        .u   (u_raw)
    );

    // line the fraction up with the slower tangent dividers
    crpi_delay #(
        .WIDTH (F + 1),
        .DEPTH (LT - LF)
    ) u_frac_dly (
        .clk  (clk),
        .en   (en),
        .din  (u_raw),
        .dout (u_dly)
    );

    crpi_tan_div #(
        .TIME_BITS (TB)
    ) u_tan1 (
        .clk   (clk),
        .en    (en),
        .chord (c1_reg),
        .span  (dt_reg),
        .den   (d1_reg),
        .tan   (m1),
        .clip  (clip1)
    );

    crpi_tan_div #(
        .TIME_BITS (TB)
    ) u_tan2 (
        .clk   (clk),
        .en    (en),
        .chord (c2_reg),
        .span  (dt_reg),
        .den   (d2_reg),
        .tan   (m2),
        .clip  (clip2)
    );

    crpi_delay #(
        .WIDTH (KW),
        .DEPTH (LT)
    ) u_knot_dly (
        .clk  (clk),
        .en   (en),
        .din  (knot_reg),
        .dout (knot_dly)
    );

    assign side.p1    = knot_dly.p1;
    assign side.p2    = knot_dly.p2;
    assign side.m1    = m1;
    assign side.m2    = m2;
    assign side.degen = knot_dly.degen;
    assign side.tclip = clip1 | clip2;

    crpi_blend #(
        .FRACTION_BITS (F)
    ) u_blend (
        .clk   (clk),
        .en    (en),
        .u     (u_dly),
        .side  (side),
        .pos   (pos),
        .degen (degen),
        .sat   (sat)
    );

    // valid bits ride along with the stages
    always_comb
    begin
        vld_next = en ? {vld_reg[LAT-2:0], s_tvalid} : vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata  = pos;
    assign m_tuser  = {sat, degen};

`ifndef SYNTHESIS
    a_degen_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> !m_tuser[1])
        else $error("degenerate word flagged as saturated");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while output stalled");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted word not in first stage");
`endif

endmodule
